@@ rtl/core/ekfsm_pkg.sv @@
// ----------------------------------------------------------------------------
// ekfsm_pkg
// Types and constants shared by the entropy key session state machine.
// ----------------------------------------------------------------------------
package ekfsm_pkg;

	typedef enum logic [2:0] {
		ST_INIT      = 3'd0,
		ST_SESSION   = 3'd1,
		ST_SENT      = 3'd2,
		ST_KFIRST    = 3'd3,
		ST_KEYED     = 3'd4,
		ST_KBAD      = 3'd5,
		ST_UNTRUSTED = 3'd6,
		ST_CLOSED    = 3'd7
	} conn_state_t;

	localparam logic [2:0] PK_SERIAL  = 3'd0;
	localparam logic [2:0] PK_INFO    = 3'd1;
	localparam logic [2:0] PK_KEYREQ  = 3'd2;
	localparam logic [2:0] PK_KEY     = 3'd3;
	localparam logic [2:0] PK_ENTROPY = 3'd4;
	localparam logic [2:0] PK_REJECT  = 3'd5;
	localparam logic [2:0] PK_END     = 3'd6;

	localparam logic       REG_MAX_REPEAT = 1'b0;
	localparam logic       REG_MAX_REKEY  = 1'b1;

	localparam logic [7:0]  SERIAL_BYTES   = 8'd12;
	localparam logic [11:0] NONCE_BYTES    = 12'd12;
	localparam logic [11:0] LAST_SEQ       = 12'd4095;
	localparam logic [7:0]  DEF_MAX_REPEAT = 8'd5;
	localparam logic [7:0]  DEF_MAX_REKEY  = 8'd50;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  packet_length;
		logic [63:0] serial_low;
		logic [31:0] serial_high;
		logic [11:0] subcode;
		logic        key_known;
		logic        nonce_ok;
	} item_t;

	typedef struct packed {
		conn_state_t next_state;
		logic        send_reset;
		logic        send_key_request;
		logic [31:0] nonce_number;
		logic        load_default_key;
		logic        derive_session_key;
		logic        pass_entropy;
	} result_t;

endpackage

@@ rtl/core/ekfsm_in_stage.sv @@
// ----------------------------------------------------------------------------
// ekfsm_in_stage
// Input register: holds one accepted word until the decision stage takes it.
// ----------------------------------------------------------------------------
module ekfsm_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ekfsm_pkg::item_t in_item,
	input  logic           take,
	output logic           valid_s1,
	output ekfsm_pkg::item_t item_s1
);
	import ekfsm_pkg::*;

	logic load;

	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ rtl/core/ekfsm_core.sv @@
// ----------------------------------------------------------------------------
// ekfsm_core
// Session state, counters and stored serial; per-word next state and actions.
// ----------------------------------------------------------------------------
module ekfsm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [7:0]        wr_data,
	input  logic              fire,
	input  ekfsm_pkg::item_t  item,
	output ekfsm_pkg::result_t result
);
	import ekfsm_pkg::*;

	conn_state_t state_q, state_d;
	logic [7:0]  max_repeat_q, max_rekey_q;
	logic [7:0]  repeat_q, repeat_d;
	logic [63:0] ser_lo_q, ser_lo_d;
	logic [31:0] ser_hi_q, ser_hi_d;
	logic        ser_valid_q, ser_valid_d;
	logic [31:0] nonce_q, nonce_d;
	logic [31:0] reset_total_q;
	logic [31:0] rekey_total_q;
	logic        reset_inc, rekey_inc;

	always_comb begin
		logic do_reset;
		logic do_keyreq;
		do_reset    = 1'b0;
		do_keyreq   = 1'b0;
		state_d     = state_q;
		repeat_d    = repeat_q;
		ser_lo_d    = ser_lo_q;
		ser_hi_d    = ser_hi_q;
		ser_valid_d = ser_valid_q;
		nonce_d     = nonce_q;
		rekey_inc   = 1'b0;
		result      = '0;

		if (state_q == ST_CLOSED) begin
			state_d = ST_CLOSED;
		end else if (item.func >= PK_END) begin
			state_d = ST_CLOSED;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (item.func != PK_SERIAL) begin
						do_reset = 1'b1;
					end else if (item.packet_length < SERIAL_BYTES) begin
						do_reset = 1'b1;
					end else if (ser_valid_q && (ser_lo_q != item.serial_low ||
							ser_hi_q != item.serial_high)) begin
						state_d = ST_UNTRUSTED;
					end else begin
						if (!ser_valid_q) begin
							ser_lo_d    = item.serial_low;
							ser_hi_d    = item.serial_high;
							ser_valid_d = 1'b1;
						end
						result.load_default_key = 1'b1;
						state_d = item.key_known ? ST_SESSION : ST_UNTRUSTED;
					end
				end
				ST_SESSION: begin
					if (item.func == PK_INFO) state_d = state_q;
					else if (item.func == PK_KEYREQ) do_keyreq = 1'b1;
					else do_reset = 1'b1;
				end
				ST_SENT: begin
					if (item.func == PK_INFO) begin
						state_d = state_q;
					end else if (item.func == PK_KEYREQ) begin
						repeat_d = repeat_q + 8'd1;
						if (repeat_q >= max_repeat_q) do_reset = 1'b1;
					end else if (item.func == PK_KEY) begin
						if (item.subcode != NONCE_BYTES) begin
							do_reset = 1'b1;
						end else begin
							result.derive_session_key = 1'b1;
							rekey_inc = 1'b1;
							state_d   = ST_KFIRST;
						end
					end else begin
						do_reset = 1'b1;
					end
				end
				ST_KFIRST, ST_KEYED: begin
					if (item.func == PK_ENTROPY) begin
						result.pass_entropy = 1'b1;
						if (item.subcode == LAST_SEQ) do_keyreq = 1'b1;
						else state_d = ST_KEYED;
					end else if (item.func == PK_INFO) begin
						state_d = state_q;
					end else if (state_q == ST_KFIRST && item.func == PK_REJECT) begin
						do_reset = 1'b1;
					end else if (state_q == ST_KEYED && item.func == PK_KEYREQ) begin
						do_keyreq = 1'b1;
					end else begin
						do_reset = 1'b1;
					end
				end
				ST_KBAD: begin
					if (item.func == PK_KEYREQ) begin
						repeat_d = repeat_q + 8'd1;
						if (repeat_q >= max_rekey_q) do_reset = 1'b1;
					end
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end

		if (do_keyreq) begin
			if (!item.nonce_ok) begin
				state_d = ST_UNTRUSTED;
			end else begin
				result.send_key_request = 1'b1;
				result.nonce_number     = nonce_q;
				nonce_d  = nonce_q + 32'd1;
				repeat_d = '0;
				state_d  = ST_SENT;
			end
		end
		if (do_reset) begin
			result.send_reset       = 1'b1;
			result.load_default_key = 1'b1;
			state_d = ST_INIT;
			// rejected key: reset action, then wait in keyed-bad
			if (state_q == ST_KFIRST && item.func == PK_REJECT) begin
				repeat_d = '0;
				state_d  = ST_KBAD;
			end
		end
		reset_inc = do_reset;
		result.next_state = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_repeat_q <= DEF_MAX_REPEAT;
			max_rekey_q  <= DEF_MAX_REKEY;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAX_REPEAT: max_repeat_q <= wr_data;
				REG_MAX_REKEY:  max_rekey_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			repeat_q      <= '0;
			ser_lo_q      <= '0;
			ser_hi_q      <= '0;
			ser_valid_q   <= 1'b0;
			nonce_q       <= '0;
			reset_total_q <= '0;
			rekey_total_q <= '0;
		end else if (fire) begin
			state_q       <= state_d;
			repeat_q      <= repeat_d;
			ser_lo_q      <= ser_lo_d;
			ser_hi_q      <= ser_hi_d;
			ser_valid_q   <= ser_valid_d;
			nonce_q       <= nonce_d;
			reset_total_q <= reset_total_q + {31'd0, reset_inc};
			rekey_total_q <= rekey_total_q + {31'd0, rekey_inc};
		end
	end

endmodule

@@ rtl/core/ekfsm_out_stage.sv @@
// ----------------------------------------------------------------------------
// ekfsm_out_stage
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module ekfsm_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  ekfsm_pkg::result_t  result_d,
	output logic                take,
	output logic                out_valid,
	input  logic                out_stall,
	output ekfsm_pkg::result_t  result_q
);
	import ekfsm_pkg::*;

	assign take = valid_s1 && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= take || (out_valid && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result_d;
		end
	end

endmodule

@@ rtl/core/entropy_key_session_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// entropy_key_session_fsm_unit
// Host-side session state machine for a keyed entropy device.
// ----------------------------------------------------------------------------
// One word in gives one result word out. A word is registered, decided
// against the session state, and lands in the result register, so the block
// takes one word per cycle unless out_stall holds a result; the state, repeat,
// nonce, serial and count registers all loop back. The user must write limits
// through wr_en/wr_index/wr_data while the block is idle; nothing enforces it.
module entropy_key_session_fsm_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [7:0]  wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  packet_length,
	input  logic [63:0] serial_low,
	input  logic [31:0] serial_high,
	input  logic [11:0] subcode,
	input  logic        key_known,
	input  logic        nonce_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  next_state,
	output logic        send_reset,
	output logic        send_key_request,
	output logic [31:0] nonce_number,
	output logic        load_default_key,
	output logic        derive_session_key,
	output logic        pass_entropy
);
	import ekfsm_pkg::*;

	item_t   in_item, item_s1;
	result_t result_d, result_q;
	logic    valid_s1, take;

	assign in_item = '{func: func, packet_length: packet_length,
		serial_low: serial_low, serial_high: serial_high, subcode: subcode,
		key_known: key_known, nonce_ok: nonce_ok};

	ekfsm_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ekfsm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.fire     (take),
		.item     (item_s1),
		.result   (result_d)
	);

	ekfsm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result_d  (result_d),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_q  (result_q)
	);

	assign next_state         = result_q.next_state;
	assign send_reset         = result_q.send_reset;
	assign send_key_request   = result_q.send_key_request;
	assign nonce_number       = result_q.nonce_number;
	assign load_default_key   = result_q.load_default_key;
	assign derive_session_key = result_q.derive_session_key;
	assign pass_entropy       = result_q.pass_entropy;

endmodule
